[rtl/core/pfc_pkg.sv]
package pfc_pkg;

   // Conversion selected by the mode register.
   typedef enum logic [1:0] {
      MODE_GRAY   = 2'd0,
      MODE_VIDEO  = 2'd1,
      MODE_LUMA   = 2'd2,
      MODE_REPACK = 2'd3
   } mode_type;

   // One component layout: truncation shift over bit offset.
   typedef struct packed {
      logic [2:0] shift;
      logic [4:0] offset;
   } layout_type;

   // Complete configuration as seen by the pipeline stages.
   typedef struct packed {
      mode_type   mode;
      layout_type src_red;
      layout_type src_green;
      layout_type src_blue;
      layout_type dst_red;
      layout_type dst_green;
      layout_type dst_blue;
      logic [2:0] dst_bytes;
   } cfg_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_SRC_RED   = 3'd1;
   localparam logic [2:0] CSR_SRC_GREEN = 3'd2;
   localparam logic [2:0] CSR_SRC_BLUE  = 3'd3;
   localparam logic [2:0] CSR_DST_RED   = 3'd4;
   localparam logic [2:0] CSR_DST_GREEN = 3'd5;
   localparam logic [2:0] CSR_DST_BLUE  = 3'd6;
   localparam logic [2:0] CSR_DST_BYTES = 3'd7;

   // Reset values of the layout registers.
   localparam logic [7:0] LAYOUT_BYTE0 = 8'd0;
   localparam logic [7:0] LAYOUT_BYTE1 = 8'd8;
   localparam logic [7:0] LAYOUT_BYTE2 = 8'd16;

   // Destination byte counts that select a mask wider than one byte.
   localparam logic [2:0] BYTES_TWO   = 3'd2;
   localparam logic [2:0] BYTES_THREE = 3'd3;
   localparam logic [2:0] BYTES_FOUR  = 3'd4;

   // Luma weights and rounding bias.
   localparam logic [15:0] WEIGHT_RED   = 16'd77;
   localparam logic [15:0] WEIGHT_GREEN = 16'd150;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd29;
   localparam logic [15:0] ROUND_BIAS   = 16'h0080;

   // Video range limits. Scaling by 255/219 is a multiply by the rounded-up
   // reciprocal 255 * 2^16 / 219; over the offsets 1..218 the error stays
   // far below one step, so the top byte is the truncated quotient.
   localparam logic [7:0]  VIDEO_BLACK = 8'd16;
   localparam logic [7:0]  VIDEO_WHITE = 8'd235;
   localparam logic [7:0]  FULL_WHITE  = 8'hff;
   localparam logic [16:0] VIDEO_RECIP = 17'd76310;

   // Pull one 8-bit component out of a source pixel.
   function automatic logic [7:0] take_component(input logic [31:0] pix,
                                                 input layout_type layout);
      logic [31:0] aligned;
      logic [7:0]  low;
      aligned = pix >> layout.offset;
      low     = aligned[7:0];
      return low << layout.shift;
   endfunction

   // Place one 8-bit component into a destination pixel.
   function automatic logic [31:0] place_component(input logic [7:0] value,
                                                   input layout_type layout);
      logic [31:0] wide;
      wide = {24'd0, value >> layout.shift};
      return wide << layout.offset;
   endfunction

endpackage

[rtl/core/pfc_unpack.sv]
// First stage: pulls the red, green and blue components and the luma byte
// out of the source pixel.
module pfc_unpack (
   input  logic             clock,
   input  logic             reset,
   input  pfc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      in_pixel,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_red,
   output logic [7:0]       out_green,
   output logic [7:0]       out_blue,
   output logic [7:0]       out_luma
);

   logic       valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff, luma_ff;
   logic [7:0] red_in, green_in, blue_in, luma_in;

   // The stage takes a request whenever it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;

   // Component extraction.
   always_comb begin
      red_in   = pfc_pkg::take_component(in_pixel, cfg.src_red);
      green_in = pfc_pkg::take_component(in_pixel, cfg.src_green);
      blue_in  = pfc_pkg::take_component(in_pixel, cfg.src_blue);
      luma_in  = in_pixel[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         luma_ff  <= luma_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;
   assign out_luma  = luma_ff;

endmodule

[rtl/core/pfc_scale.sv]
// Second and third stages: the weighted luma sum and the video range product
// are formed and registered, then the components to be packed are chosen.
// In luma mode the luma byte leaves on the red lane.
module pfc_scale (
   input  logic             clock,
   input  logic             reset,
   input  pfc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_red,
   input  logic [7:0]       in_green,
   input  logic [7:0]       in_blue,
   input  logic [7:0]       in_luma,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_red,
   output logic [7:0]       out_green,
   output logic [7:0]       out_blue
);

   // Product stage registers.
   logic        prod_valid_ff;
   logic        prod_ready;
   logic [7:0]  red_ff, green_ff, blue_ff, luma_ff;
   logic [15:0] luma_sum_ff, luma_sum_in;
   logic [23:0] video_prod_ff, video_prod_in;
   logic        video_black_ff, video_black_in;
   logic        video_white_ff, video_white_in;

   // Select stage registers.
   logic        sel_valid_ff;
   logic [7:0]  sel_red_ff, sel_green_ff, sel_blue_ff;
   logic [7:0]  sel_red_in, sel_green_in, sel_blue_in;

   logic [7:0]  video_offset;
   logic [24:0] video_prod_wide;
   logic [7:0]  video_level;

   assign prod_ready = !sel_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   // Weighted sum with rounding, and the video offset times the reciprocal.
   always_comb begin
      luma_sum_in = {8'd0, in_red} * pfc_pkg::WEIGHT_RED
                  + {8'd0, in_green} * pfc_pkg::WEIGHT_GREEN
                  + {8'd0, in_blue} * pfc_pkg::WEIGHT_BLUE
                  + pfc_pkg::ROUND_BIAS;
      video_black_in  = in_luma <= pfc_pkg::VIDEO_BLACK;
      video_white_in  = in_luma >= pfc_pkg::VIDEO_WHITE;
      video_offset    = in_luma - pfc_pkg::VIDEO_BLACK;
      video_prod_wide = {17'd0, video_offset} * {8'd0, pfc_pkg::VIDEO_RECIP};
      video_prod_in   = video_prod_wide[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (in_ready) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff         <= in_red;
         green_ff       <= in_green;
         blue_ff        <= in_blue;
         luma_ff        <= in_luma;
         luma_sum_ff    <= luma_sum_in;
         video_prod_ff  <= video_prod_in;
         video_black_ff <= video_black_in;
         video_white_ff <= video_white_in;
      end
   end

   // Clamp the expanded video luma at both ends of the range.
   always_comb begin
      priority if (video_black_ff) begin
         video_level = 8'd0;
      end else if (video_white_ff) begin
         video_level = pfc_pkg::FULL_WHITE;
      end else begin
         video_level = video_prod_ff[23:16];
      end
   end

   // Choose what goes to the packer for the current mode.
   always_comb begin
      unique case (cfg.mode)
         pfc_pkg::MODE_GRAY: begin
            sel_red_in   = luma_ff;
            sel_green_in = luma_ff;
            sel_blue_in  = luma_ff;
         end
         pfc_pkg::MODE_VIDEO: begin
            sel_red_in   = video_level;
            sel_green_in = video_level;
            sel_blue_in  = video_level;
         end
         pfc_pkg::MODE_LUMA: begin
            sel_red_in   = luma_sum_ff[15:8];
            sel_green_in = 8'd0;
            sel_blue_in  = 8'd0;
         end
         default: begin
            sel_red_in   = red_ff;
            sel_green_in = green_ff;
            sel_blue_in  = blue_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         sel_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid_ff) begin
         sel_red_ff   <= sel_red_in;
         sel_green_ff <= sel_green_in;
         sel_blue_ff  <= sel_blue_in;
      end
   end

   assign out_valid = sel_valid_ff;
   assign out_red   = sel_red_ff;
   assign out_green = sel_green_ff;
   assign out_blue  = sel_blue_ff;

endmodule

[rtl/core/pfc_pack.sv]
// Last stage: places the components into the destination layout, masks the
// pixel to dst_bytes (one byte in luma mode) and holds it as the response.
module pfc_pack (
   input  logic             clock,
   input  logic             reset,
   input  pfc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_red,
   input  logic [7:0]       in_green,
   input  logic [7:0]       in_blue,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      out_pixel
);

   logic        valid_ff;
   logic [31:0] pixel_ff, pixel_in;
   logic [31:0] packed_pixel;

   assign in_ready = !valid_ff || out_ready;

   // Overlapping destination components are ORed together.
   always_comb begin
      packed_pixel = pfc_pkg::place_component(in_red, cfg.dst_red)
                   | pfc_pkg::place_component(in_green, cfg.dst_green)
                   | pfc_pkg::place_component(in_blue, cfg.dst_blue);
      if (cfg.mode == pfc_pkg::MODE_LUMA) begin
         pixel_in = {24'd0, in_red};
      end else begin
         unique case (cfg.dst_bytes)
            pfc_pkg::BYTES_TWO:   pixel_in = {16'd0, packed_pixel[15:0]};
            pfc_pkg::BYTES_THREE: pixel_in = {8'd0, packed_pixel[23:0]};
            pfc_pkg::BYTES_FOUR:  pixel_in = packed_pixel;
            default:              pixel_in = {24'd0, packed_pixel[7:0]};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

[rtl/core/pixel_format_converter.sv]
// Pixel format converter: one request word carries one pixel, and each
// request gives exactly one response word. The mode register picks gray to
// RGB, video-range luma to RGB, RGB to luma (weights 77/150/29, rounded) or
// RGB repacking; layout registers give each component's bit offset and
// truncation shift, and dst_bytes masks the packed RGB result. A pixel passes
// four register stages (unpack, multiply, select, pack) before its response is
// valid. The pipeline accepts a new pixel on every cycle while the response
// side does not stall; stalls from the response side propagate back stage by
// stage without losing or repeating data. Configuration is to be written while
// the pipeline is empty.
module pixel_format_converter (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_in
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] pixel_out
);

   pfc_pkg::cfg_type cfg_ff, cfg_in;

   logic       unp_valid, unp_ready;
   logic [7:0] unp_red, unp_green, unp_blue, unp_luma;
   logic       scl_valid, scl_ready;
   logic [7:0] scl_red, scl_green, scl_blue;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pfc_pkg::CSR_MODE:      cfg_in.mode      = pfc_pkg::mode_type'(csr_wdata[1:0]);
            pfc_pkg::CSR_SRC_RED:   cfg_in.src_red   = csr_wdata;
            pfc_pkg::CSR_SRC_GREEN: cfg_in.src_green = csr_wdata;
            pfc_pkg::CSR_SRC_BLUE:  cfg_in.src_blue  = csr_wdata;
            pfc_pkg::CSR_DST_RED:   cfg_in.dst_red   = csr_wdata;
            pfc_pkg::CSR_DST_GREEN: cfg_in.dst_green = csr_wdata;
            pfc_pkg::CSR_DST_BLUE:  cfg_in.dst_blue  = csr_wdata;
            pfc_pkg::CSR_DST_BYTES: cfg_in.dst_bytes = csr_wdata[2:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= pfc_pkg::MODE_GRAY;
         cfg_ff.src_red   <= pfc_pkg::LAYOUT_BYTE0;
         cfg_ff.src_green <= pfc_pkg::LAYOUT_BYTE1;
         cfg_ff.src_blue  <= pfc_pkg::LAYOUT_BYTE2;
         cfg_ff.dst_red   <= pfc_pkg::LAYOUT_BYTE0;
         cfg_ff.dst_green <= pfc_pkg::LAYOUT_BYTE1;
         cfg_ff.dst_blue  <= pfc_pkg::LAYOUT_BYTE2;
         cfg_ff.dst_bytes <= pfc_pkg::BYTES_THREE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Component extraction.
   pfc_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (req_tdata),
      .out_valid (unp_valid),
      .out_ready (unp_ready),
      .out_red   (unp_red),
      .out_green (unp_green),
      .out_blue  (unp_blue),
      .out_luma  (unp_luma)
   );

   // Luma weighting, video expansion and selection.
   pfc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (unp_valid),
      .in_ready  (unp_ready),
      .in_red    (unp_red),
      .in_green  (unp_green),
      .in_blue   (unp_blue),
      .in_luma   (unp_luma),
      .out_valid (scl_valid),
      .out_ready (scl_ready),
      .out_red   (scl_red),
      .out_green (scl_green),
      .out_blue  (scl_blue)
   );

   // Destination packing and response register.
   pfc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (scl_valid),
      .in_ready  (scl_ready),
      .in_red    (scl_red),
      .in_green  (scl_green),
      .in_blue   (scl_blue),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (rsp_tdata)
   );

endmodule
